// ----- rtl/mbt_pkg.sv -----
// ----------------------------------------------------------------------------
// mbt_pkg: shared types and constants for the multigraph bridge test unit
// Item layouts, controller/datapath interface structs and state encoding.
// ----------------------------------------------------------------------------
package mbt_pkg;

  // Store geometry
  localparam int MAX_V = 16;
  localparam int VW    = $clog2(MAX_V);
  localparam int AW    = 2 * VW;
  localparam int DEPTH = MAX_V * MAX_V;
  localparam int MW    = 8;
  localparam int CW    = 5;

  // Item command codes
  typedef enum logic [0:0] {
    CMD_SET   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t          command;
    logic [VW-1:0] first_vertex;
    logic [VW-1:0] second_vertex;
    logic [MW-1:0] multiplicity;
  } in_item_t;

  typedef struct packed {
    logic          bridge_flag;
    logic [MW-1:0] multiplicity_seen;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic latch;
    logic wr_fwd;
    logic wr_rev;
    logic rd;
    logic chk;
    logic step;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic eligible;
    logic search_done;
  } dp_sts_t;

  // Controller states, one-hot
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_WRA  = 7'b0000010,
    S_WRB  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_CHK  = 7'b0010000,
    S_SRCH = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

endpackage

// ----- rtl/mbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbt_ctrl: sequencing state machine
// Steps each item through store writes or the query read, check and search.
// ----------------------------------------------------------------------------
module mbt_ctrl import mbt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  cmd_t    in_cmd,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy
);

  state_t state_r, state_nxt;

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Decode next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = (in_cmd == CMD_SET) ? S_WRA : S_RD;
        end
      end
      S_WRA: begin
        cmd.wr_fwd = 1'b1;
        state_nxt  = S_WRB;
      end
      S_WRB: begin
        cmd.wr_rev = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.chk   = 1'b1;
        state_nxt = sts.eligible ? S_SRCH : S_DONE;
      end
      S_SRCH: begin
        if (sts.search_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_DONE: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/mbt_dpath.sv -----
// ----------------------------------------------------------------------------
// mbt_dpath: adjacency store and reachability search
// Multiplicity memory, edge presence matrix, reached set and result register.
// ----------------------------------------------------------------------------
module mbt_dpath import mbt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  in_item_t      in_item,
  input  logic          cfg_wr_en,
  input  logic [CW-1:0] cfg_wr_data,
  input  dp_cmd_t       cmd,
  output dp_sts_t       sts,
  output logic          out_valid,
  output out_item_t     out_item
);

  logic [MW-1:0]    mem [DEPTH];
  logic [MAX_V-1:0] adj_r [MAX_V];
  logic [MAX_V-1:0] vld_r [MAX_V];

  in_item_t         item_r;
  logic [CW-1:0]    vc_r;
  logic [MW-1:0]    rd_data_r;
  logic             rd_vld_r;
  logic [MW-1:0]    seen_r;
  logic             elig_r;
  logic [MAX_V-1:0] reached_r, expanded_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic [VW-1:0]    va, vb, pick;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;
  logic             nz;
  logic [CW-1:0]    lim;
  logic [MAX_V-1:0] use_mask, pending, row;
  logic [MW-1:0]    seen;

  assign va = item_r.first_vertex;
  assign vb = item_r.second_vertex;
  assign nz = (item_r.multiplicity != '0);

  // Clamp vertex count to the store size and build the in-use mask
  always_comb begin
    lim = (vc_r > CW'(MAX_V)) ? CW'(MAX_V) : vc_r;
    for (int u = 0; u < MAX_V; u++) begin
      use_mask[u] = (CW'(u) < lim);
    end
  end

  // Hold the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= CW'(MAX_V);
    end else if (cfg_wr_en) begin
      vc_r <= cfg_wr_data;
    end
  end

  // Latch the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
    end
  end

  // Multiplicity memory: one write or one read per cycle
  assign wr_en   = cmd.wr_fwd | cmd.wr_rev;
  assign wr_addr = cmd.wr_fwd ? {va, vb} : {vb, va};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= item_r.multiplicity;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[{va, vb}];
    end
  end

  // Edge presence and entry valid bits, both directions at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_V; i++) begin
        adj_r[i] <= '0;
        vld_r[i] <= '0;
      end
    end else if (cmd.wr_fwd) begin
      adj_r[va][vb] <= nz;
      adj_r[vb][va] <= nz;
      vld_r[va][vb] <= 1'b1;
      vld_r[vb][va] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_vld_r <= vld_r[va][vb];
    end
  end

  // Never-written entries read as zero
  assign seen = rd_vld_r ? rd_data_r : '0;

  assign sts.eligible = (seen == MW'(1)) && (va != vb) && use_mask[va] && use_mask[vb];

  // Pick the lowest reached vertex not yet expanded
  assign pending = reached_r & ~expanded_r;

  always_comb begin
    pick = '0;
    for (int i = MAX_V - 1; i >= 0; i--) begin
      if (pending[i]) begin
        pick = VW'(i);
      end
    end
  end

  // Neighbors of the picked vertex, without the tested edge
  always_comb begin
    row = adj_r[pick] & use_mask;
    if (pick == va) begin
      row[vb] = 1'b0;
    end
    if (pick == vb) begin
      row[va] = 1'b0;
    end
  end

  assign sts.search_done = (pending == '0) || reached_r[vb];

  // Start the reached set at the first vertex on check, then grow it by expanding one vertex per cycle while searching
  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      seen_r     <= seen;
      elig_r     <= sts.eligible;
      reached_r  <= MAX_V'(1) << va;
      expanded_r <= '0;
    end else if (cmd.step) begin
      reached_r        <= reached_r | row;
      expanded_r[pick] <= 1'b1;
    end
  end

  // Register the result and its one-cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.bridge_flag       <= elig_r & ~reached_r[vb];
      out_r.multiplicity_seen <= seen_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- rtl/multigraph_bridge_test_unit.sv -----
// ----------------------------------------------------------------------------
// multigraph_bridge_test_unit: bridge test on a small symmetric multigraph
// Stores edge multiplicities and answers whether a queried edge is a bridge.
// ----------------------------------------------------------------------------
// Items are taken when start is high and busy is low. A set-edge item writes
// both (a,b) and (b,a) through the single memory port and gives no result. A
// query gives exactly one result, shown on out_item for one cycle with
// out_valid high, and the receiver cannot stall it. A query whose edge is not
// a simple edge between two vertices in use skips the search; otherwise the
// search expands one reached vertex per cycle until the far endpoint is
// reached or the reached set stops growing. The far endpoint is never
// expanded, so at most one less than the vertices in use (vertex_count,
// capped at 16) are expanded. The result strobe is high in the first cycle
// that busy is low again. vertex_count may be written only while busy is low
// and no result is pending.
module multigraph_bridge_test_unit import mbt_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_item_t      in_item,
  input  logic          cfg_wr_en,
  input  logic [CW-1:0] cfg_wr_data,
  output logic          out_valid,
  output out_item_t     out_item
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mbt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_item.command),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  mbt_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

endmodule
